// ===== design/mwsm_pkg.sv =====
// Shared types, constants and the sine table of the mecanum wheel speed mixer.
package mwsm_pkg;

  // Fixed field widths
  localparam int CH_W     = 11;
  localparam int HEAD_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int WHEEL_W  = 14;
  localparam int NWHEEL   = 4;
  localparam int CFG_IDX_W = 2;

  // Fixed behavior constants
  localparam int TARGET_LIMIT    = 7800;
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int CENTRE          = 1024;
  localparam int SIN_ONE_SHIFT   = 15;
  localparam int ROUND_SHIFT     = 23;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FORWARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_STRAFE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TURN    = 2'd2;

  // Angle reduction
  localparam int ANGLE_UNITS   = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER_UNITS = 90 << ANGLE_FRAC_BITS;
  localparam int ANGLE_W       = $clog2(ANGLE_UNITS);
  localparam int ANGLE_OFFSET  = ((32768 + ANGLE_UNITS - 1) / ANGLE_UNITS) * ANGLE_UNITS;
  localparam int REDUCE_STEPS  = (32767 + ANGLE_OFFSET) / ANGLE_UNITS;
  localparam int OFFSET_W      = $clog2(32768 + ANGLE_OFFSET);
  localparam int DEG_W         = ANGLE_W - ANGLE_FRAC_BITS;
  localparam int FRAC_W        = ANGLE_FRAC_BITS;
  localparam int ROUND_HALF    = 1 << (ANGLE_FRAC_BITS - 1);

  // Datapath widths
  localparam int SPEED_W = CH_W + 1 + GAIN_W + 1;   // centred channel times gain
  localparam int SIN_W   = 17;                      // holds +-32768
  localparam int PROD_W  = SPEED_W + SIN_W;
  localparam int ROT_W   = PROD_W + 1;
  localparam int ACC_W   = ROT_W + 3;
  localparam int T_W     = ACC_W - ROUND_SHIFT;

  localparam logic [SIN_W-1:0] QSINE [0:90] = '{
    17'd0,     17'd572,   17'd1144,  17'd1715,  17'd2286,  17'd2856,  17'd3425,
    17'd3993,  17'd4560,  17'd5126,  17'd5690,  17'd6252,  17'd6813,  17'd7371,
    17'd7927,  17'd8481,  17'd9032,  17'd9580,  17'd10126, 17'd10668, 17'd11207,
    17'd11743, 17'd12275, 17'd12803, 17'd13328, 17'd13848, 17'd14365, 17'd14876,
    17'd15384, 17'd15886, 17'd16384, 17'd16877, 17'd17364, 17'd17847, 17'd18324,
    17'd18795, 17'd19261, 17'd19720, 17'd20174, 17'd20622, 17'd21063, 17'd21498,
    17'd21926, 17'd22348, 17'd22763, 17'd23170, 17'd23571, 17'd23965, 17'd24351,
    17'd24730, 17'd25102, 17'd25466, 17'd25822, 17'd26170, 17'd26510, 17'd26842,
    17'd27166, 17'd27482, 17'd27789, 17'd28088, 17'd28378, 17'd28660, 17'd28932,
    17'd29197, 17'd29452, 17'd29698, 17'd29935, 17'd30163, 17'd30382, 17'd30592,
    17'd30792, 17'd30983, 17'd31164, 17'd31336, 17'd31499, 17'd31651, 17'd31795,
    17'd31928, 17'd32052, 17'd32166, 17'd32270, 17'd32365, 17'd32449, 17'd32524,
    17'd32588, 17'd32643, 17'd32688, 17'd32723, 17'd32748, 17'd32763, 17'd32768
  };

  // Full-wave sine of a whole degree, 0..360
  function automatic logic signed [SIN_W-1:0] sine_deg(input logic [DEG_W-1:0] k);
    logic [SIN_W-1:0] m;
    logic             neg;
    if (k <= DEG_W'(90)) begin
      m   = QSINE[7'(k)];
      neg = 1'b0;
    end else if (k <= DEG_W'(180)) begin
      m   = QSINE[7'(DEG_W'(180) - k)];
      neg = 1'b0;
    end else if (k <= DEG_W'(270)) begin
      m   = QSINE[7'(k - DEG_W'(180))];
      neg = 1'b1;
    end else begin
      m   = QSINE[7'(DEG_W'(360) - k)];
      neg = 1'b1;
    end
    return neg ? -$signed(m) : $signed(m);
  endfunction

  typedef struct packed {
    logic signed [SPEED_W-1:0] vx;
    logic signed [SPEED_W-1:0] vy;
    logic signed [SPEED_W-1:0] vw;
  } speed_t;

  typedef struct packed {
    speed_t             spd;
    logic [ANGLE_W-1:0] ang;
  } front_t;

  typedef struct packed {
    speed_t                  spd;
    logic signed [SIN_W-1:0] sa;
    logic signed [SIN_W-1:0] sb;
    logic [FRAC_W-1:0]       sf;
    logic signed [SIN_W-1:0] ca;
    logic signed [SIN_W-1:0] cb;
    logic [FRAC_W-1:0]       cf;
  } look_t;

  typedef struct packed {
    speed_t                  spd;
    logic signed [SIN_W-1:0] s;
    logic signed [SIN_W-1:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [ROT_W-1:0]   rx;
    logic signed [ROT_W-1:0]   ry;
    logic signed [SPEED_W-1:0] vw;
  } rot_t;

endpackage

// ===== design/mwsm_front.sv =====
// First stage: channel centering and gain, heading reduction modulo a full turn.
module mwsm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_in,
  input  logic [mwsm_pkg::CH_W-1:0]      stick_forward,
  input  logic [mwsm_pkg::CH_W-1:0]      stick_strafe,
  input  logic [mwsm_pkg::CH_W-1:0]      stick_turn,
  input  logic signed [mwsm_pkg::HEAD_W-1:0] heading_angle,
  input  logic [mwsm_pkg::GAIN_W-1:0]    gain_forward,
  input  logic [mwsm_pkg::GAIN_W-1:0]    gain_strafe,
  input  logic [mwsm_pkg::GAIN_W-1:0]    gain_turn,
  output logic                           valid_r,
  output mwsm_pkg::front_t               data_r
);

  localparam int CW = mwsm_pkg::CH_W + 1;
  localparam int OW = mwsm_pkg::OFFSET_W;
  localparam int SW = mwsm_pkg::SPEED_W;

  logic signed [CW-1:0] cf, cs, ct;
  logic [OW-1:0]        a_off;
  logic [OW-1:0]        rem;
  mwsm_pkg::front_t     data_nxt;

  always_comb begin
    cf = $signed({1'b0, stick_forward}) - $signed(CW'(mwsm_pkg::CENTRE));
    cs = $signed({1'b0, stick_strafe})  - $signed(CW'(mwsm_pkg::CENTRE));
    ct = $signed({1'b0, stick_turn})    - $signed(CW'(mwsm_pkg::CENTRE));
    data_nxt.spd.vx = SW'(cf) * SW'($signed({1'b0, gain_forward}));
    data_nxt.spd.vy = SW'(cs) * SW'($signed({1'b0, gain_strafe}));
    data_nxt.spd.vw = SW'(ct) * SW'($signed({1'b0, gain_turn}));

    // shift to non-negative, then subtract the largest fitting multiple of a turn
    a_off = {{(OW - mwsm_pkg::HEAD_W){heading_angle[mwsm_pkg::HEAD_W-1]}}, heading_angle}
            + OW'(mwsm_pkg::ANGLE_OFFSET);
    rem = a_off;
    for (int k = 1; k <= mwsm_pkg::REDUCE_STEPS; k++) begin
      if (a_off >= OW'(k * mwsm_pkg::ANGLE_UNITS)) begin
        rem = a_off - OW'(k * mwsm_pkg::ANGLE_UNITS);
      end
    end
    data_nxt.ang = rem[mwsm_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/mwsm_trig.sv =====
// Sine and cosine of the heading: table lookup stage, then interpolation stage.
module mwsm_trig (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  mwsm_pkg::front_t data_in,
  output logic             valid_r,
  output mwsm_pkg::trig_t  data_r
);

  localparam int AW = mwsm_pkg::ANGLE_W;
  localparam int F  = mwsm_pkg::ANGLE_FRAC_BITS;
  localparam int DW = mwsm_pkg::DEG_W;
  localparam int IW = mwsm_pkg::SIN_W + F + 2;

  function automatic logic signed [mwsm_pkg::SIN_W-1:0] interp(
    input logic signed [mwsm_pkg::SIN_W-1:0] a,
    input logic signed [mwsm_pkg::SIN_W-1:0] b,
    input logic [mwsm_pkg::FRAC_W-1:0]       f
  );
    logic signed [IW-1:0] diff;
    logic signed [IW-1:0] v;
    diff = IW'(b) - IW'(a);
    v = (IW'(a) <<< F) + diff * IW'($signed({1'b0, f})) + IW'(mwsm_pkg::ROUND_HALF);
    return v[F +: mwsm_pkg::SIN_W];
  endfunction

  logic [AW:0]      rc_sum;
  logic [AW-1:0]    rc;
  logic [DW-1:0]    ds, dc;
  mwsm_pkg::look_t  look_nxt, look_r;
  logic             look_valid_r;
  mwsm_pkg::trig_t  data_nxt;

  // lookup stage: cosine angle is the sine angle plus a quarter turn
  always_comb begin
    rc_sum = {1'b0, data_in.ang} + (AW + 1)'(mwsm_pkg::QUARTER_UNITS);
    if (rc_sum >= (AW + 1)'(mwsm_pkg::ANGLE_UNITS)) begin
      rc_sum = rc_sum - (AW + 1)'(mwsm_pkg::ANGLE_UNITS);
    end
    rc = rc_sum[AW-1:0];
    ds = data_in.ang[AW-1:F];
    dc = rc[AW-1:F];
    look_nxt.spd = data_in.spd;
    look_nxt.sa  = mwsm_pkg::sine_deg(ds);
    look_nxt.sb  = mwsm_pkg::sine_deg(ds + DW'(1));
    look_nxt.sf  = data_in.ang[F-1:0];
    look_nxt.ca  = mwsm_pkg::sine_deg(dc);
    look_nxt.cb  = mwsm_pkg::sine_deg(dc + DW'(1));
    look_nxt.cf  = rc[F-1:0];
  end

  always_comb begin
    data_nxt.spd = look_r.spd;
    data_nxt.s   = interp(look_r.sa, look_r.sb, look_r.sf);
    data_nxt.c   = interp(look_r.ca, look_r.cb, look_r.cf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_valid_r <= 1'b0;
      valid_r      <= 1'b0;
    end else if (en) begin
      look_valid_r <= valid_in;
      valid_r      <= look_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      look_r <= look_nxt;
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/mwsm_rotate.sv =====
// Rotation of the translation vector: product stage, then sum stage.
module mwsm_rotate (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_in,
  input  mwsm_pkg::trig_t data_in,
  output logic            valid_r,
  output mwsm_pkg::rot_t  data_r
);

  localparam int PW = mwsm_pkg::PROD_W;
  localparam int RW = mwsm_pkg::ROT_W;

  logic signed [PW-1:0]               pxs_r, pyc_r, pxc_r, pys_r;
  logic signed [mwsm_pkg::SPEED_W-1:0] vw_r;
  logic                               prod_valid_r;
  mwsm_pkg::rot_t                     data_nxt;

  always_comb begin
    data_nxt.ry = RW'(pxs_r) + RW'(pyc_r);
    data_nxt.rx = RW'(pxc_r) - RW'(pys_r);
    data_nxt.vw = vw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      valid_r      <= 1'b0;
    end else if (en) begin
      prod_valid_r <= valid_in;
      valid_r      <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxs_r  <= PW'(data_in.spd.vx) * PW'(data_in.s);
      pyc_r  <= PW'(data_in.spd.vy) * PW'(data_in.c);
      pxc_r  <= PW'(data_in.spd.vx) * PW'(data_in.c);
      pys_r  <= PW'(data_in.spd.vy) * PW'(data_in.s);
      vw_r   <= data_in.spd.vw;
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/mwsm_mix.sv =====
// Last stage: wheel mixing, rounding, clamping and the output register.
module mwsm_mix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_in,
  input  mwsm_pkg::rot_t                    data_in,
  output logic                              valid_r,
  output logic [mwsm_pkg::WHEEL_W-1:0]      wheel_r [mwsm_pkg::NWHEEL],
  output logic [mwsm_pkg::NWHEEL-1:0]       flags_r
);

  localparam int AW = mwsm_pkg::ACC_W;
  localparam int TW = mwsm_pkg::T_W;

  logic signed [AW-1:0] rx, ry, w;
  logic signed [AW-1:0] acc [mwsm_pkg::NWHEEL];
  logic signed [AW-1:0] rnd;
  logic signed [TW-1:0] t;
  logic [mwsm_pkg::WHEEL_W-1:0] wheel_nxt [mwsm_pkg::NWHEEL];
  logic [mwsm_pkg::NWHEEL-1:0]  flags_nxt;

  always_comb begin
    rx = AW'(data_in.rx);
    ry = AW'(data_in.ry);
    w  = AW'(data_in.vw) <<< mwsm_pkg::SIN_ONE_SHIFT;
    acc[0] = -rx + ry + w;
    acc[1] =  rx + ry + w;
    acc[2] =  rx - ry + w;
    acc[3] = -rx - ry + w;
    flags_nxt = '0;
    for (int i = 0; i < mwsm_pkg::NWHEEL; i++) begin
      rnd = acc[i] + AW'(1 << (mwsm_pkg::ROUND_SHIFT - 1));
      t   = rnd[AW-1:mwsm_pkg::ROUND_SHIFT];
      if (t > TW'(mwsm_pkg::TARGET_LIMIT)) begin
        t = TW'(mwsm_pkg::TARGET_LIMIT);
        flags_nxt[i] = 1'b1;
      end else if (t < -TW'(mwsm_pkg::TARGET_LIMIT)) begin
        t = -TW'(mwsm_pkg::TARGET_LIMIT);
        flags_nxt[i] = 1'b1;
      end
      wheel_nxt[i] = t[mwsm_pkg::WHEEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wheel_r <= wheel_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

// ===== design/mecanum_wheel_speed_mixer_unit.sv =====
// Top level of the mecanum wheel speed mixer: gain registers, pipeline and stall control.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   in_     | in  | stick_forward, stick_strafe, stick_turn, heading_angle
//   out_    | out | wheel_front_a, wheel_front_b, wheel_rear_b, wheel_rear_a, clamp_flags
//   cfg_    | in  | cfg_index selects gain_forward / gain_strafe / gain_turn
//
// Six register stages: scale and angle reduce, table lookup, interpolation, products,
// rotation sums, mix and clamp. One beat enters per cycle while the pipeline advances.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so a stalled output holds every stage and no beat is lost or repeated.
// Reset clears the stage valid bits and loads all gains with 1.0 (256).
module mecanum_wheel_speed_mixer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [10:0] stick_forward, [21:11] stick_strafe, [32:22] stick_turn,
  // [48:33] heading_angle, [55:49] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] wheel_front_a, [27:14] wheel_front_b, [41:28] wheel_rear_b,
  // [55:42] wheel_rear_a, [59:56] clamp_flags, [63:60] zero
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mwsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwsm_pkg::GAIN_W-1:0]    cfg_data
);

  localparam int CW = mwsm_pkg::CH_W;
  localparam int WW = mwsm_pkg::WHEEL_W;

  logic [mwsm_pkg::GAIN_W-1:0] gain_forward_r, gain_strafe_r, gain_turn_r;
  logic                        en;
  logic                        front_valid, trig_valid, rot_valid;
  mwsm_pkg::front_t            front_data;
  mwsm_pkg::trig_t             trig_data;
  mwsm_pkg::rot_t              rot_data;
  logic [WW-1:0]               wheel [mwsm_pkg::NWHEEL];
  logic [mwsm_pkg::NWHEEL-1:0] flags;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_forward_r <= mwsm_pkg::GAIN_RESET;
      gain_strafe_r  <= mwsm_pkg::GAIN_RESET;
      gain_turn_r    <= mwsm_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mwsm_pkg::REG_GAIN_FORWARD: gain_forward_r <= cfg_data;
        mwsm_pkg::REG_GAIN_STRAFE:  gain_strafe_r  <= cfg_data;
        mwsm_pkg::REG_GAIN_TURN:    gain_turn_r    <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  mwsm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .valid_in      (in_tvalid),
    .stick_forward (in_tdata[CW-1:0]),
    .stick_strafe  (in_tdata[2*CW-1:CW]),
    .stick_turn    (in_tdata[3*CW-1:2*CW]),
    .heading_angle ($signed(in_tdata[3*CW+mwsm_pkg::HEAD_W-1:3*CW])),
    .gain_forward  (gain_forward_r),
    .gain_strafe   (gain_strafe_r),
    .gain_turn     (gain_turn_r),
    .valid_r       (front_valid),
    .data_r        (front_data)
  );

  mwsm_trig u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (front_valid),
    .data_in  (front_data),
    .valid_r  (trig_valid),
    .data_r   (trig_data)
  );

  mwsm_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (trig_valid),
    .data_in  (trig_data),
    .valid_r  (rot_valid),
    .data_r   (rot_data)
  );

  mwsm_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (rot_valid),
    .data_in  (rot_data),
    .valid_r  (out_tvalid),
    .wheel_r  (wheel),
    .flags_r  (flags)
  );

  assign out_tdata = {4'b0, flags, wheel[3], wheel[2], wheel[1], wheel[0]};

  // a flagged wheel 0 sits exactly on a limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flags[0] |->
      $signed(wheel[0]) == WW'(mwsm_pkg::TARGET_LIMIT) ||
      $signed(wheel[0]) == -WW'(mwsm_pkg::TARGET_LIMIT))
    else $error("wheel 0 flagged but not at limit");

  // the targets of wheels 1 and 2 stay inside the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      $signed(wheel[1]) <= WW'(mwsm_pkg::TARGET_LIMIT) &&
      $signed(wheel[1]) >= -WW'(mwsm_pkg::TARGET_LIMIT) &&
      $signed(wheel[2]) <= WW'(mwsm_pkg::TARGET_LIMIT) &&
      $signed(wheel[2]) >= -WW'(mwsm_pkg::TARGET_LIMIT))
    else $error("wheel target outside limit");

  // with the sink always ready, an accepted beat comes out through every stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) ##1 out_tready ##1 out_tready
      ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("beat lost in pipeline");

  // nothing enters while the output holds a stalled beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(front_data) && $stable(trig_data))
    else $error("pipeline moved during stall");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the mecanum wheel speed mixer: corners, gains, traffic, stalls.
module tb_top;

  localparam int CW = mwsm_pkg::CH_W;
  localparam int HW = mwsm_pkg::HEAD_W;
  localparam int GW = mwsm_pkg::GAIN_W;
  localparam int WW = mwsm_pkg::WHEEL_W;
  localparam int NW = mwsm_pkg::NWHEEL;
  localparam int XW = mwsm_pkg::CFG_IDX_W;
  localparam int FB = mwsm_pkg::ANGLE_FRAC_BITS;

  localparam logic [XW-1:0] REG_SPARE = 2'd3;  // unmapped index, writes are dropped
  localparam int PIPE_DEPTH   = 6;
  localparam int MAX_CYCLES   = 200000;
  localparam int RANDOM_ITEMS = 720;
  localparam int RANDOM_PHASES = 8;
  localparam int STICK_CENTRE = 1024;
  localparam int FULL_TURN    = 360 << FB;
  localparam int QUARTER_TURN = 90 << FB;
  localparam int MAX_PRINTS   = 40;
  localparam logic [GW-1:0] UNITY_GAIN = 16'd256;

  // sin(k deg) * 32768 for k = 0..90
  localparam int SINE_Q [0:90] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  // last field in the lowest bits
  typedef struct packed {
    logic [HW-1:0] heading;
    logic [CW-1:0] turn;
    logic [CW-1:0] strafe;
    logic [CW-1:0] fwd;
  } stick_cmd_t;

  // wheels[0] front_a, [1] front_b, [2] rear_b, [3] rear_a
  typedef struct packed {
    logic [NW-1:0]         flags;
    logic [NW-1:0][WW-1:0] wheels;
  } wheel_set_t;

  localparam string WHEEL_NAME [NW] = '{"front_a", "front_b", "rear_b", "rear_a"};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [XW-1:0] cfg_index = '0;
  logic [GW-1:0] cfg_data = '0;

  // gain copies used for prediction
  logic [GW-1:0] gain_fwd = UNITY_GAIN;
  logic [GW-1:0] gain_str = UNITY_GAIN;
  logic [GW-1:0] gain_trn = UNITY_GAIN;

  wheel_set_t wheel_queue [$];
  int  errors = 0;
  int  cmds_sent = 0;
  int  beats_checked = 0;
  int  clamped_beats = 0;
  int  cfg_writes = 0;
  int  in_stall_cycles = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  bit  tx_idling = 1'b1;
  bit  rx_idling = 1'b1;

  mecanum_wheel_speed_mixer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic longint sine_of_degree(input int k);
    int m;
    m = k % 360;
    if (m < 0) m += 360;
    if (m <= 90) return SINE_Q[m];
    if (m <= 180) return SINE_Q[180 - m];
    if (m <= 270) return -SINE_Q[m - 180];
    return -SINE_Q[360 - m];
  endfunction

  // r is a reduced angle in 1/16 degree; interpolate and round half up
  function automatic longint sine_of_angle(input int r);
    int     d, f;
    longint a, b, v;
    d = r >>> FB;
    f = r & ((1 << FB) - 1);
    a = sine_of_degree(d);
    b = sine_of_degree(d + 1);
    v = (a <<< FB) + (b - a) * f + (longint'(1) <<< (FB - 1));
    return v >>> FB;
  endfunction

  function automatic void wheel_limit(input longint acc, output logic [WW-1:0] t14,
                                      output logic hit);
    longint t;
    t = (acc + (longint'(1) <<< 22)) >>> 23;
    hit = 1'b0;
    if (t > mwsm_pkg::TARGET_LIMIT) begin
      t = mwsm_pkg::TARGET_LIMIT;
      hit = 1'b1;
    end else if (t < -mwsm_pkg::TARGET_LIMIT) begin
      t = -mwsm_pkg::TARGET_LIMIT;
      hit = 1'b1;
    end
    t14 = WW'(t);
  endfunction

  function automatic wheel_set_t predict_wheels(input stick_cmd_t c);
    longint vx, vy, vw, s, co, rx, ry, w;
    longint acc [NW];
    int     r, rc;
    logic [WW-1:0] t;
    logic   hit;
    wheel_set_t e;
    vx = (longint'(c.fwd) - STICK_CENTRE) * longint'(gain_fwd);
    vy = (longint'(c.strafe) - STICK_CENTRE) * longint'(gain_str);
    vw = (longint'(c.turn) - STICK_CENTRE) * longint'(gain_trn);
    r = int'($signed(c.heading)) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    rc = r + QUARTER_TURN;
    if (rc >= FULL_TURN) rc -= FULL_TURN;
    s  = sine_of_angle(r);
    co = sine_of_angle(rc);
    ry = vx * s + vy * co;
    rx = vx * co - vy * s;
    w  = vw * 32768;
    acc[0] = -rx + ry + w;
    acc[1] =  rx + ry + w;
    acc[2] =  rx - ry + w;
    acc[3] = -rx - ry + w;
    e = '0;
    for (int i = 0; i < NW; i++) begin
      wheel_limit(acc[i], t, hit);
      e.wheels[i] = t;
      e.flags[i]  = hit;
    end
    return e;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTS) $display("MISMATCH at beat %0d: %s", beats_checked, what);
    errors++;
  endtask

  task automatic send_cmd(input stick_cmd_t c);
    while (tx_idling && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, c};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    wheel_queue.push_back(predict_wheels(c));
    cmds_sent++;
  endtask

  task automatic send_sticks(input int fwd, input int str, input int trn, input int head);
    stick_cmd_t c;
    c.fwd     = CW'(fwd);
    c.strafe  = CW'(str);
    c.turn    = CW'(trn);
    c.heading = HW'(head);
    send_cmd(c);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (wheel_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_gain(input logic [XW-1:0] idx, input logic [GW-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mwsm_pkg::REG_GAIN_FORWARD: gain_fwd = val;
      mwsm_pkg::REG_GAIN_STRAFE:  gain_str = val;
      mwsm_pkg::REG_GAIN_TURN:    gain_trn = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_all_gains(input logic [GW-1:0] gf, input logic [GW-1:0] gs,
                                 input logic [GW-1:0] gt);
    write_gain(mwsm_pkg::REG_GAIN_FORWARD, gf);
    write_gain(mwsm_pkg::REG_GAIN_STRAFE, gs);
    write_gain(mwsm_pkg::REG_GAIN_TURN, gt);
  endtask

  function automatic logic [CW-1:0] random_stick();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return CW'(STICK_CENTRE - 16 + int'($urandom_range(32)));
      default: return CW'($urandom_range(2047));
    endcase
  endfunction

  function automatic logic [GW-1:0] random_gain();
    case ($urandom_range(4))
      0: return GW'($urandom_range(512));
      1: return GW'($urandom_range(2048, 256));
      2: return GW'($urandom());
      3: return UNITY_GAIN;
      default: return GW'($urandom_range(4096));
    endcase
  endfunction

  function automatic stick_cmd_t random_cmd();
    stick_cmd_t c;
    c.fwd    = random_stick();
    c.strafe = random_stick();
    c.turn   = random_stick();
    // a quarter of headings stay within two turns, whole degrees half the time
    case ($urandom_range(7))
      0: c.heading = HW'(int'($urandom_range(1440)) * 16 - 11520);
      1: c.heading = HW'(int'($urandom_range(23040)) - 11520);
      default: c.heading = HW'($urandom());
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_request - 1;
      hold_request = 0;
    end else begin
      out_tready <= !(rx_idling && $urandom_range(99) < 12);
    end
  end

  // handshake signals settle by the falling edge and hold until the next rising one
  always @(negedge clk) begin : check_beat
    wheel_set_t got, want;
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[59:0];
      if (wheel_queue.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = wheel_queue.pop_front();
        for (int i = 0; i < NW; i++)
          if (got.wheels[i] !== want.wheels[i])
            report_mismatch($sformatf("wheel_%s got %0d expected %0d", WHEEL_NAME[i],
                                      $signed(got.wheels[i]), $signed(want.wheels[i])));
        if (got.flags !== want.flags)
          report_mismatch($sformatf("clamp_flags got %b expected %b", got.flags, want.flags));
      end
      if (got.flags != '0) clamped_beats++;
      beats_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               wheel_queue.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_stick_and_angle_corners();
    send_sticks(1024, 1024, 1024, 0);
    send_sticks(2047, 1024, 1024, 0);
    send_sticks(0, 1024, 1024, 0);
    send_sticks(1024, 2047, 1024, 0);
    send_sticks(1024, 0, 1024, 0);
    send_sticks(1024, 1024, 2047, 0);
    send_sticks(1024, 1024, 0, 0);
    send_sticks(2047, 2047, 2047, 0);
    send_sticks(0, 0, 0, 0);
    send_sticks(2047, 0, 1024, QUARTER_TURN);
    send_sticks(2047, 0, 1024, 2 * QUARTER_TURN);
    send_sticks(2047, 2047, 1024, 3 * QUARTER_TURN);
    send_sticks(2047, 1024, 1024, FULL_TURN);        // exactly one turn wraps to zero
    send_sticks(2047, 1024, 1024, -1);
    send_sticks(2047, 2047, 1024, -32768);
    send_sticks(0, 2047, 1024, 32767);
    send_sticks(2047, 0, 1024, 8);                   // half degree, rounding tie
    send_sticks(2047, 2047, 1024, 15);
    send_sticks(1500, 700, 1024, -1432);
    send_sticks(2047, 2047, 2047, 16'h5A5A);
  endtask

  task automatic test_gain_corners();
    // zero gain kills every channel
    write_all_gains('0, '0, '0);
    send_sticks(2047, 0, 2047, 100);
    send_sticks(0, 2047, 0, -3000);
    // full gain saturates both ways
    write_all_gains('1, '1, '1);
    send_sticks(2047, 2047, 2047, 0);
    send_sticks(0, 0, 0, 0);
    send_sticks(2047, 0, 1024, 720);
    send_sticks(1024, 1024, 1024, 0);
    // turn only: 975 * 2048 / 256 lands exactly on the limit, one more step goes past it
    write_all_gains('0, '0, 16'd2048);
    send_sticks(1024, 1024, 1024 + 975, 0);
    send_sticks(1024, 1024, 1024 + 976, 0);
    send_sticks(1024, 1024, 1024 - 975, 0);
    send_sticks(1024, 1024, 1024 - 976, 0);
    // unmapped index must leave every gain alone
    write_gain(REG_SPARE, '1);
    send_sticks(1024, 1024, 1024 + 976, 0);
    send_sticks(2047, 0, 2047, 300);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) write_all_gains(UNITY_GAIN, UNITY_GAIN, UNITY_GAIN);
      else write_all_gains(random_gain(), random_gain(), random_gain());
      // one phase runs flat out on both sides
      tx_idling = (p != 2);
      rx_idling = (p != 2);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) send_cmd(random_cmd());
    end
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    hold_request = 80;
    tx_idling = 1'b0;
    repeat (40) send_cmd(random_cmd());
    tx_idling = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (12) send_cmd(random_cmd());
    wait_drained();
    repeat (12) send_cmd(random_cmd());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stick_and_angle_corners();
    test_gain_corners();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    wait_drained();
    $display("covered %0d stick commands over %0d gain writes; %0d results checked",
             cmds_sent, cfg_writes, beats_checked);
    $display("%0d results clamped, input held off for %0d cycles by backpressure",
             clamped_beats, in_stall_cycles);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
